[hw/rtl/hsha_pkg.sv]
// ----------------------------------------------------------------------------
// hsha_pkg
// shared types, constants and sha-256 round functions for the hmac engine
// ----------------------------------------------------------------------------
package hsha_pkg;

  localparam int NumKeyRegs = 8;
  localparam int KeyRegW    = 64;
  localparam int CfgIdxW    = 3;
  localparam int FifoDepth  = 4;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  word_bytes;
    logic        last_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] mac_word;
    logic [2:0]  word_index;
    logic        last_word;
  } mac_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } cmd_t;

  // handshake between the sequencer and the compression core
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  typedef enum logic [3:0] {
    S_RESET, S_KEY_IPAD, S_KEY_OPAD, S_IDLE, S_BYTE, S_COMP, S_PAD, S_LEN,
    S_INNER, S_OUTER, S_EMIT
  } seq_state_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam word_t InitH [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[hw/rtl/hsha_if.sv]
// ----------------------------------------------------------------------------
// hsha_if
// valid/ready stream channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface hsha_if #(
  parameter type payload_t = logic [31:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/hsha_front.sv]
// ----------------------------------------------------------------------------
// hsha_front
// accepts message words, clamps byte counts, queues them for the back end
// ----------------------------------------------------------------------------
module hsha_front
  import hsha_pkg::*;
#(
  parameter int Depth = FifoDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  msg_item_t in_item,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output cmd_t      cmd
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;
  cmd_t            cls;

  always_comb begin
    cls.data = in_item.msg_word;
    cls.nbytes = (in_item.word_bytes > 3'd4) ? 3'd4 : in_item.word_bytes;
    cls.last = in_item.last_of_message;
  end

  assign in_ready  = (count != (AW+1)'(Depth));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[hw/rtl/hsha_core.sv]
// ----------------------------------------------------------------------------
// hsha_core
// sha-256 compression, one round per cycle, schedule in a 16-word window
// ----------------------------------------------------------------------------
module hsha_core
  import hsha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_t     init_st [8],
  input  word_t     blk [16],
  output core_ctl_t ctl,
  output word_t     result [8]
);
  word_t       w [16];
  word_t       v [8];
  word_t       h [8];
  logic [5:0]  rnd;
  logic        busy;
  logic        done;
  word_t       t1;
  word_t       t2;
  word_t       wn;

  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + w[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign wn = w[0] + sig0(w[1]) + w[9] + sig1(w[14]);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[i];
      for (int i = 0; i < 8; i++) begin
        v[i] <= init_st[i];
        h[i] <= init_st[i];
      end
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl.start = start;
    ctl.busy  = busy;
    ctl.done  = done;
    // v holds the state after round 64 while done is high
    for (int i = 0; i < 8; i++) result[i] = h[i] + v[i];
  end
endmodule

[hw/rtl/hsha_back.sv]
// ----------------------------------------------------------------------------
// hsha_back
// sequencer: key setup, byte packing, padding, inner and outer hash, emit
// ----------------------------------------------------------------------------
module hsha_back
  import hsha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [KeyRegW-1:0]  key [NumKeyRegs],
  input  logic                key_dirty,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output mac_item_t           out_item,
  output logic                ready_flag
);
  seq_state_t  state;
  seq_state_t  state_next;
  word_t       buf_w [16];
  logic [5:0]  fill;
  logic [31:0] byte_count;
  word_t       chain [8];
  word_t       istart [8];
  word_t       ostart [8];
  word_t       mac_res [8];
  logic        kready;
  logic        key_stale;
  cmd_t        cur;
  logic [2:0]  bidx;
  logic [2:0]  oidx;
  word_t       core_init [8];
  word_t       core_blk [16];
  word_t       core_res [8];
  core_ctl_t   ctl;
  logic        core_start;
  logic [7:0]  cur_byte;
  logic [7:0]  pad_byte;
  logic        byte_wr;
  logic        load_cur;

  hsha_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (core_start),
    .init_st (core_init),
    .blk     (core_blk),
    .ctl     (ctl),
    .result  (core_res)
  );

  assign cur_byte = cur.data[5'(24 - 8 * int'(bidx)) +: 8];
  assign ready_flag = kready;

  always_comb begin
    core_init = chain;
    core_blk  = buf_w;
    case (state)
      S_KEY_IPAD: begin
        core_init = InitH;
        for (int r = 0; r < NumKeyRegs; r++) begin
          core_blk[2*r]   = key[r][63:32] ^ {4{IpadByte}};
          core_blk[2*r+1] = key[r][31:0] ^ {4{IpadByte}};
        end
      end
      S_KEY_OPAD: begin
        core_init = InitH;
        for (int r = 0; r < NumKeyRegs; r++) begin
          core_blk[2*r]   = key[r][63:32] ^ {4{OpadByte}};
          core_blk[2*r+1] = key[r][31:0] ^ {4{OpadByte}};
        end
      end
      S_LEN: begin
        // length field: bit count modulo 2^32, upper word zero
        core_blk[14] = '0;
        core_blk[15] = {byte_count[28:0], 3'b000};
      end
      S_OUTER: begin
        core_init = ostart;
        for (int i = 0; i < 8; i++) core_blk[i] = chain[i];
        core_blk[8] = 32'h80000000;
        for (int i = 9; i < 15; i++) core_blk[i] = '0;
        core_blk[15] = 32'd768;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    core_start = 1'b0;
    byte_wr    = 1'b0;
    pad_byte   = cur_byte;
    load_cur   = 1'b0;
    case (state)
      S_RESET: state_next = S_KEY_IPAD;
      S_KEY_IPAD: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_KEY_OPAD;
      end
      S_KEY_OPAD: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (!kready) begin
          state_next = S_KEY_IPAD;
        end else if (cmd_valid) begin
          cmd_ready  = 1'b1;
          load_cur   = 1'b1;
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        if (bidx == cur.nbytes) begin
          state_next = cur.last ? S_PAD : S_IDLE;
        end else begin
          byte_wr = 1'b1;
          if (fill == 6'd63) state_next = S_COMP;
        end
      end
      S_COMP: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_BYTE;
      end
      S_PAD: begin
        byte_wr  = 1'b1;
        pad_byte = (bidx == 3'd7) ? 8'h00 : 8'h80;
        if (fill == 6'd63) state_next = S_INNER;
        else if (fill == 6'd55) state_next = S_LEN;
      end
      S_LEN: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_OUTER;
      end
      S_INNER: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_PAD;
      end
      S_OUTER: begin
        core_start = !ctl.busy && !ctl.done;
        if (ctl.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && oidx == 3'd7) state_next = S_IDLE;
      end
      default: state_next = S_RESET;
    endcase
  end

  assign out_valid = (state == S_EMIT);
  always_comb begin
    out_item.mac_word   = mac_res[oidx];
    out_item.word_index = oidx;
    out_item.last_word  = (oidx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RESET;
      kready     <= 1'b0;
      key_stale  <= 1'b0;
      fill       <= '0;
      byte_count <= 32'd64;
      bidx       <= '0;
      oidx       <= '0;
    end else begin
      state <= state_next;
      if (key_dirty) kready <= 1'b0;
      // a key write during setup means the start values must be redone
      if (key_dirty) key_stale <= 1'b1;
      else if (state == S_KEY_IPAD && core_start) key_stale <= 1'b0;
      if (load_cur) begin
        cur  <= cmd;
        bidx <= '0;
      end
      if (byte_wr) begin
        buf_w[fill[5:2]][5'(24 - 8 * int'(fill[1:0])) +: 8] <= pad_byte;
        fill <= fill + 1'b1;
        if (state == S_BYTE) begin
          bidx       <= bidx + 1'b1;
          byte_count <= byte_count + 1'b1;
        end else begin
          // bidx 7 marks padding past the 0x80 byte
          bidx <= 3'd7;
        end
      end
      if (ctl.done) begin
        case (state)
          S_KEY_IPAD: istart <= core_res;
          S_KEY_OPAD: begin
            ostart     <= core_res;
            chain      <= istart;
            fill       <= '0;
            byte_count <= 32'd64;
            if (!key_dirty && !key_stale) kready <= 1'b1;
          end
          S_COMP, S_INNER: chain <= core_res;
          S_LEN: chain <= core_res;
          S_OUTER: begin
            mac_res <= core_res;
            oidx    <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_EMIT && out_ready) begin
        oidx <= oidx + 1'b1;
        if (oidx == 3'd7) begin
          chain      <= istart;
          fill       <= '0;
          byte_count <= 32'd64;
        end
      end
    end
  end
endmodule

[hw/rtl/hmac_sha256_engine.sv]
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// hmac-sha-256 over a stream of big-endian message words
// ----------------------------------------------------------------------------
// usage
//   in channel: msg_word, word_bytes, last_of_message; one word per transfer
//   out channel: eight mac words per message, word_index 0..7, last_word on 7
//   config: cfg_we, cfg_index, cfg_data write the eight 64-bit key registers
//     while idle; any key write triggers a new key setup before the next word
// sequencing
//   a queue of four words decouples the input from the sequencer
//   each word is fetched from the queue, written into the block one byte at
//   a time and then checked; a full block starts a compression, during which
//   the sequencer takes no further word or byte
//   the last word adds padding bytes and two or three compressions (an extra
//   block when the padding does not fit, the length block, the outer hash)
// reset
//   after rst two compressions derive the inner and outer start values;
//   input words queue meanwhile
// stall
//   results hold on the out channel until taken; the queue keeps filling
// ----------------------------------------------------------------------------
module hmac_sha256_engine
  import hsha_pkg::*;
#(
  parameter int QueueDepth = FifoDepth
) (
  input  logic                clk,
  input  logic                rst,
  hsha_if.sink                msg_in,
  hsha_if.source              mac_out,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [KeyRegW-1:0]  cfg_data
);
  logic [KeyRegW-1:0] key [NumKeyRegs];
  logic               key_dirty;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;
  logic               kready;

  // key registers, every write forces a fresh key setup
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumKeyRegs; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end
  assign key_dirty = cfg_we;

  hsha_front #(.Depth(QueueDepth)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg_in.valid),
    .in_ready  (msg_in.ready),
    .in_item   (msg_in.data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  hsha_back u_back (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .key_dirty  (key_dirty),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (mac_out.valid),
    .out_ready  (mac_out.ready),
    .out_item   (mac_out.data),
    .ready_flag (kready)
  );

  // no word leaves the queue before the start values exist
  a_no_cmd_wo_key: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> kready) else $error("word taken before key setup");

  // results come in order, one index step per transfer
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (mac_out.valid && mac_out.ready && !mac_out.data.last_word) |=>
      (mac_out.data.word_index == $past(mac_out.data.word_index) + 3'd1))
    else $error("mac word index skipped");

  // a result never coincides with a word being taken
  a_excl: assert property (@(posedge clk) disable iff (rst)
    mac_out.valid |-> !cmd_ready) else $error("emit overlaps intake");
endmodule

[verif/tb_hmac_sha256_engine.sv]
// ----------------------------------------------------------------------------
// tb_hmac_sha256_engine
// self-checking bench for the hmac-sha-256 engine: keyed messages are streamed
// in with bursty valid and a stalling receiver, and every mac word is compared
// with an in-bench hmac predictor
// ----------------------------------------------------------------------------
module tb_hmac_sha256_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import hsha_pkg::*;

  // hmac predictor plus the queue of mac words it expects
  class mac_scoreboard;
    logic [KeyRegW-1:0] key_reg [NumKeyRegs];
    word_t              blk_buf [16];
    word_t              chain [8];
    word_t              istart [8];
    word_t              ostart [8];
    int unsigned        fill;
    logic [31:0]        total_bytes;
    bit                 starts_valid;
    mac_item_t          expected_macs [$];
    int unsigned        errors;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      foreach (blk_buf[i]) blk_buf[i] = '0;
      fill = 0;
      total_bytes = 64;
      starts_valid = 0;
      errors = 0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(inout word_t st [8], input word_t blk [16]);
      word_t w [64];
      word_t a [8];
      word_t t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = st;
      for (int i = 0; i < 64; i++) begin
        s1 = ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25);
        t1 = a[7] + s1 + ((a[4] & a[5]) ^ (~a[4] & a[6])) + RoundK[i] + w[i];
        s0 = ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22);
        t2 = s0 + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
        for (int j = 7; j > 0; j--) a[j] = a[j-1];
        a[4] = a[4] + t1;
        a[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) st[i] = st[i] + a[i];
    endfunction

    function void restart();
      chain = istart;
      fill = 0;
      total_bytes = 64;
    endfunction

    function void derive_starts();
      word_t blk [16];
      for (int r = 0; r < NumKeyRegs; r++) begin
        blk[2*r]   = key_reg[r][63:32] ^ {4{IpadByte}};
        blk[2*r+1] = key_reg[r][31:0]  ^ {4{IpadByte}};
      end
      istart = InitH;
      compress(istart, blk);
      for (int r = 0; r < NumKeyRegs; r++) begin
        blk[2*r]   = key_reg[r][63:32] ^ {4{OpadByte}};
        blk[2*r+1] = key_reg[r][31:0]  ^ {4{OpadByte}};
      end
      ostart = InitH;
      compress(ostart, blk);
      restart();
      starts_valid = 1;
    endfunction

    function void absorb(logic [7:0] b);
      blk_buf[fill >> 2][24 - 8 * (fill & 3) +: 8] = b;
      fill++;
      if (fill >= 64) begin
        compress(chain, blk_buf);
        fill = 0;
      end
    endfunction

    function void write_key(int idx, logic [KeyRegW-1:0] v);
      if (idx < NumKeyRegs) begin
        key_reg[idx] = v;
        starts_valid = 0;
      end
    endfunction

    // accepted input word: absorb it, and on the last word queue the mac
    function void note_word(msg_item_t it);
      int    nb;
      word_t fin [16];
      word_t outer [8];
      if (!starts_valid) derive_starts();
      nb = (it.word_bytes > 4) ? 4 : it.word_bytes;
      for (int i = 0; i < nb; i++) begin
        absorb(it.msg_word[31 - 8 * i -: 8]);
        total_bytes++;
      end
      if (!it.last_of_message) return;
      absorb(8'h80);
      if (fill > 56) while (fill != 0) absorb(8'h00);
      while (fill < 56) absorb(8'h00);
      blk_buf[14] = '0;
      blk_buf[15] = total_bytes << 3;
      compress(chain, blk_buf);
      for (int i = 0; i < 8; i++) fin[i] = chain[i];
      fin[8] = 32'h8000_0000;
      for (int i = 9; i < 15; i++) fin[i] = '0;
      fin[15] = 32'((64 + 32) * 8);
      outer = ostart;
      compress(outer, fin);
      for (int i = 0; i < 8; i++)
        expected_macs.push_back('{mac_word: outer[i], word_index: 3'(i),
                                  last_word: (i == 7)});
      restart();
    endfunction

    function void check_mac(mac_item_t got);
      mac_item_t exp_item;
      if (expected_macs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected mac word %h index %0d last %0b",
                   got.mac_word, got.word_index, got.last_word);
        return;
      end
      exp_item = expected_macs.pop_front();
      if (got.mac_word !== exp_item.mac_word || got.word_index !== exp_item.word_index ||
          got.last_word !== exp_item.last_word) begin
        errors++;
        if (errors <= 10)
          $display("mac mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                   exp_item.mac_word, exp_item.word_index, exp_item.last_word,
                   got.mac_word, got.word_index, got.last_word);
      end
    endfunction

    function int pending();
      return expected_macs.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [KeyRegW-1:0]  cfg_data;

  hsha_if #(.payload_t(msg_item_t)) msg_ch ();
  hsha_if #(.payload_t(mac_item_t)) mac_ch ();

  hmac_sha256_engine dut (
    .clk       (clk),
    .rst       (rst),
    .msg_in    (msg_ch),
    .mac_out   (mac_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mac_scoreboard sb = new();
  int unsigned   words_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   phase_words;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("** hmac_sha256_engine: FAILED **");
    $finish;
  end

  // receiver: random stall pattern, plus one long hold-off once traffic is
  // flowing so the output backs up into the input queue
  initial begin
    int unsigned stall_left;
    int unsigned mode;
    bit          held;
    stall_left = 0;
    mode = 0;
    held = 0;
    mac_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= 120) begin
        held = 1;
        mac_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      // change stall style now and then: always ready, random, mostly stalled
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        mac_ch.ready <= 1'b0;
      end else if (mode == 0) begin
        mac_ch.ready <= 1'b1;
      end else if (mode == 1) begin
        mac_ch.ready <= 1'($urandom_range(0, 1));
      end else begin
        stall_left = $urandom_range(0, 20);
        mac_ch.ready <= 1'b1;
      end
    end
  end

  // output monitor: every transfer on the mac channel is checked
  always @(posedge clk) begin
    if (!rst && mac_ch.valid && mac_ch.ready) sb.check_mac(mac_ch.data);
  end

  // one input transfer; gaps fall between random-length bursts
  task automatic send_word(msg_item_t it);
    if (burst_left == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data  <= it;
    do @(posedge clk); while (!msg_ch.ready);
    sb.note_word(it);
    words_sent++;
    phase_words++;
    burst_left--;
  endtask

  task automatic send(logic [31:0] w, logic [2:0] nb, logic lst);
    send_word('{msg_word: w, word_bytes: nb, last_of_message: lst});
  endtask

  // random message: mostly short, now and then long enough to span blocks
  task automatic send_random_message();
    int unsigned len;
    logic [2:0]  nb;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
    for (int i = 0; i < len; i++) begin
      nb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send($urandom, nb, 1'b0);
    end
    send($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // idle the input, drain the results, then let the block settle
  task automatic wait_idle();
    msg_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_key(int idx, logic [KeyRegW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= CfgIdxW'(idx);
    cfg_data  <= v;
    @(posedge clk);
    sb.write_key(idx, v);
  endtask

  task automatic write_all_keys(int style);
    logic [KeyRegW-1:0] v;
    for (int r = 0; r < NumKeyRegs; r++) begin
      case (style)
        0: v = '0;
        1: v = '1;
        2: v = (r < 3) ? {$urandom, $urandom} : '0;   // short key, zero padded
        default: v = {$urandom, $urandom};
      endcase
      write_key(r, v);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    msg_ch.valid = 1'b0;
    msg_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-zero key, boundary words and byte counts
    phase_words = 0;
    write_all_keys(0);
    send(32'h0, 3'd0, 1'b1);                 // empty message
    send(32'hffff_ffff, 3'd4, 1'b1);         // one full word of ones
    send(32'h0, 3'd7, 1'b1);                 // oversize byte count on last
    send(32'ha5a5_5a5a, 3'd2, 1'b0);         // short word before last
    send(32'hdead_beef, 3'd6, 1'b1);
    for (int i = 0; i < 13; i++) send($urandom, 3'd4, 1'b0);
    send(32'hffff_ffff, 3'd3, 1'b1);         // 55 bytes, pad fits the block
    for (int i = 0; i < 14; i++) send(32'h0, (i == 5) ? 3'd5 : 3'd4, 1'b0);
    send(32'h0, 3'd0, 1'b1);                 // 56 bytes, pad needs one more block
    wait_idle();

    // random phases under varying keys, extremes included
    for (int ph = 1; ph <= 4; ph++) begin
      if (ph == 4) begin
        write_key(NumKeyRegs - 1, {$urandom, $urandom});  // one register only
        cfg_we <= 1'b0;
      end else begin
        write_all_keys(ph);
      end
      phase_words = 0;
      while (phase_words < 76) send_random_message();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** hmac_sha256_engine: PASSED **");
    end else begin
      $display("** hmac_sha256_engine: FAILED **");
    end
    $finish;
  end

endmodule
